@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fba_pkg.sv @@
`default_nettype none

package fba_pkg;

    // field and state widths
    localparam int SIZE_W    = 26;
    localparam int ALIGNED_W = 27;
    localparam int FREE_W    = 27;
    localparam int SEQ_W     = 32;

    // default configuration of the allocator
    localparam int RECORD_SLOTS_DEF = 16;
    localparam int ALIGN_BYTES_DEF  = 32;
    localparam logic [SIZE_W-1:0] CAP_RESET = 26'd1048576;
    localparam logic [FREE_W-1:0] FREE_MAX  = '1;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_WAIT    = 2'd0,
        KIND_GRANT   = 2'd1,
        KIND_TOO_BIG = 2'd2
    } t_kind;

    // classified request handed from front to back
    typedef struct packed {
        logic                 too_big;
        logic [ALIGNED_W-1:0] aligned;
    } t_item;

    // one allocation record
    typedef struct packed {
        logic              pad;
        logic [SIZE_W-1:0] size;
    } t_rec;

endpackage

`default_nettype wire

@@ rtl/core/fba_front.sv @@
`default_nettype none

module fba_front #(
    parameter int ALIGN_BYTES = fba_pkg::ALIGN_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [fba_pkg::SIZE_W-1:0]  i_request_size,
    input  wire logic [fba_pkg::SIZE_W-1:0]  i_ring_capacity,
    input  wire logic                        i_full,
    output logic                             o_push,
    output fba_pkg::t_item                   o_item
);
    import fba_pkg::*;

    // rounding by reciprocal: q = (x * RECIP) >> SHIFT is exact for x < 2^SIZE_W
    localparam int ALIGN_W = $clog2(ALIGN_BYTES + 1);
    localparam int LOG_A   = $clog2(ALIGN_BYTES);
    localparam int SHIFT   = SIZE_W + LOG_A;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + longint'(ALIGN_BYTES) - 64'd1) / longint'(ALIGN_BYTES);
    localparam int RECIP_W = SIZE_W + 1;
    localparam int PROD_W  = SIZE_W + RECIP_W;
    localparam int QA_W    = SIZE_W + ALIGN_W;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP_L);
    localparam logic [ALIGN_W-1:0] ALIGN_C = ALIGN_W'(ALIGN_BYTES);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_BACK = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate             r_state, n_state;
    logic [SIZE_W-1:0]   r_size;
    logic [PROD_W-1:0]   r_prod;
    logic [SIZE_W-1:0]   r_qa;

    logic [SIZE_W-1:0]   quot;
    logic [QA_W-1:0]     qa_full;
    logic [SIZE_W-1:0]   rem;
    logic [ALIGN_W-1:0]  pad_amt;
    logic [ALIGNED_W-1:0] aligned;

    // quotient and quotient times alignment
    always_comb begin
        quot    = SIZE_W'(r_prod >> SHIFT);
        qa_full = QA_W'(quot) * QA_W'(ALIGN_C);
    end

    // round up: add (A - rem) unless already aligned
    always_comb begin
        rem     = r_size - r_qa;
        pad_amt = ALIGN_C - rem[ALIGN_W-1:0];
        if (rem == '0) begin
            aligned = ALIGNED_W'(r_size);
        end else begin
            aligned = ALIGNED_W'(r_size) + ALIGNED_W'(pad_amt);
        end
    end

    assign o_item.aligned = aligned;
    assign o_item.too_big = (aligned > ALIGNED_W'(i_ring_capacity));
    assign busy           = (r_state != F_IDLE);

    // sequencer
    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (start) begin
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_state = F_BACK;
            end
            F_BACK: begin
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && start) begin
            r_size <= i_request_size;
        end
        if (r_state == F_MUL) begin
            r_prod <= PROD_W'(r_size) * PROD_W'(RECIP_C);
        end
        if (r_state == F_BACK) begin
            r_qa <= qa_full[SIZE_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fba_queue.sv @@
`default_nettype none

module fba_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire fba_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output fba_pkg::t_item      o_item,
    output logic                o_empty
);
    import fba_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fba_back.sv @@
`default_nettype none

module fba_back #(
    parameter int RECORD_SLOTS = fba_pkg::RECORD_SLOTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [fba_pkg::SIZE_W-1:0] i_ring_capacity,
    input  wire logic                       i_empty,
    input  wire fba_pkg::t_item             i_item,
    output logic                            o_pop,
    output logic                            o_result_strobe,
    output logic [1:0]                      o_result_kind
);
    import fba_pkg::*;

    localparam int SLOT_W = $clog2(RECORD_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RECORD_SLOTS - 1);
    localparam logic [SEQ_W-1:0]  SLOTS_C   = SEQ_W'(RECORD_SLOTS);
    localparam t_rec REC_RESET = '{pad: 1'b1, size: '0};

    typedef enum logic [4:0] {
        B_IDLE    = 5'b00001,
        B_START   = 5'b00010,
        B_WRAP    = 5'b00100,
        B_SEQ2    = 5'b01000,
        B_RECLAIM = 5'b10000
    } t_bstate;

    t_bstate            r_state, n_state;
    t_item              r_item;
    logic [SIZE_W-1:0]  r_offset, n_offset;
    logic [FREE_W-1:0]  r_free, n_free;
    logic [SEQ_W-1:0]   r_issue, r_retire;
    logic [SLOT_W-1:0]  r_issue_slot, r_retire_slot;
    logic [RECORD_SLOTS-1:0] r_rec_valid;
    t_rec               r_rec [RECORD_SLOTS];
    logic               r_strobe, n_strobe;
    t_kind              r_kind, n_kind;

    logic               do_issue, do_retire, do_sub, rec_we;
    t_rec               rec_wdata;
    logic [SIZE_W-1:0]  sub_val;
    t_rec               retire_rec;
    logic [SEQ_W-1:0]   issue_inc;
    logic [SLOT_W-1:0]  issue_slot_inc, retire_slot_inc;
    logic               seq_full;
    logic [FREE_W:0]    free_plus;
    logic [FREE_W-1:0]  free_added, free_subbed;
    logic [SIZE_W+1:0]  end_sum;
    logic               wraps;
    logic [SIZE_W-1:0]  tail;
    logic [SIZE_W-1:0]  aligned_s;
    logic               reclaim_more;

    // record at the retire slot; a slot never written reads as empty padding
    assign retire_rec = r_rec_valid[r_retire_slot] ? r_rec[r_retire_slot] : REC_RESET;

    // sequence numbers; the slot restarts at zero after the last slot or when the counter wraps
    always_comb begin
        issue_inc = r_issue + 1'b1;
        seq_full  = (issue_inc == r_retire + SLOTS_C);
        if (r_issue == '1 || r_issue_slot == SLOT_LAST) begin
            issue_slot_inc = '0;
        end else begin
            issue_slot_inc = r_issue_slot + 1'b1;
        end
        if (r_retire == '1 || r_retire_slot == SLOT_LAST) begin
            retire_slot_inc = '0;
        end else begin
            retire_slot_inc = r_retire_slot + 1'b1;
        end
    end

    // free-space arithmetic, saturating both ways
    always_comb begin
        free_plus   = (FREE_W + 1)'(r_free) + (FREE_W + 1)'(retire_rec.size);
        free_added  = free_plus[FREE_W] ? FREE_MAX : free_plus[FREE_W-1:0];
        free_subbed = (FREE_W'(sub_val) > r_free) ? '0 : r_free - FREE_W'(sub_val);
    end

    // wrap test, tail length and reclaim test
    always_comb begin
        aligned_s    = r_item.aligned[SIZE_W-1:0];
        end_sum      = (SIZE_W + 2)'(r_offset) + (SIZE_W + 2)'(r_item.aligned);
        wraps        = (end_sum > (SIZE_W + 2)'(i_ring_capacity));
        tail         = (r_offset < i_ring_capacity) ? i_ring_capacity - r_offset : '0;
        reclaim_more = (r_item.aligned > ALIGNED_W'(r_free)) && (r_retire != r_issue);
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_offset  = r_offset;
        n_strobe  = 1'b0;
        n_kind    = KIND_WAIT;
        o_pop     = 1'b0;
        do_issue  = 1'b0;
        do_retire = 1'b0;
        do_sub    = 1'b0;
        sub_val   = aligned_s;
        rec_we    = 1'b0;
        rec_wdata = '{pad: 1'b0, size: aligned_s};
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = B_START;
                end
            end
            B_START: begin
                if (r_item.too_big) begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_TOO_BIG;
                    n_state  = B_IDLE;
                end else begin
                    do_issue  = 1'b1;
                    do_retire = seq_full;
                    n_state   = B_WRAP;
                end
            end
            B_WRAP: begin
                n_state = B_RECLAIM;
                if (wraps) begin
                    n_offset = '0;
                    if (tail != '0) begin
                        rec_we    = 1'b1;
                        rec_wdata = '{pad: 1'b1, size: tail};
                        do_sub    = 1'b1;
                        sub_val   = tail;
                        n_state   = B_SEQ2;
                    end
                end
            end
            B_SEQ2: begin
                do_issue  = 1'b1;
                do_retire = seq_full;
                n_state   = B_RECLAIM;
            end
            B_RECLAIM: begin
                if (reclaim_more) begin
                    do_retire = 1'b1;
                end else begin
                    rec_we   = 1'b1;
                    do_sub   = 1'b1;
                    n_offset = r_offset + aligned_s;
                    n_strobe = 1'b1;
                    n_kind   = KIND_GRANT;
                    n_state  = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
        // a reclaimed real record asks for its fence
        if (do_retire && !retire_rec.pad) begin
            n_strobe = 1'b1;
            n_kind   = KIND_WAIT;
        end
        if (do_retire) begin
            n_free = free_added;
        end else if (do_sub) begin
            n_free = free_subbed;
        end else begin
            n_free = r_free;
        end
    end

    // control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= B_IDLE;
            r_offset      <= '0;
            r_free        <= FREE_W'(CAP_RESET);
            r_issue       <= '0;
            r_retire      <= '0;
            r_issue_slot  <= '0;
            r_retire_slot <= '0;
            r_rec_valid   <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_offset <= n_offset;
            r_free   <= n_free;
            r_strobe <= n_strobe;
            if (do_issue) begin
                r_issue      <= issue_inc;
                r_issue_slot <= issue_slot_inc;
            end
            if (do_retire) begin
                r_retire      <= r_retire + 1'b1;
                r_retire_slot <= retire_slot_inc;
            end
            if (rec_we) begin
                r_rec_valid[r_issue_slot] <= 1'b1;
            end
        end
    end

    // payload: current item, records, result kind
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (rec_we) begin
            r_rec[r_issue_slot] <= rec_wdata;
        end
        r_kind <= n_kind;
    end

    assign o_result_strobe = r_strobe;
    assign o_result_kind   = r_kind;

endmodule

`default_nettype wire

@@ rtl/core/fenced_ring_buffer_allocator.sv @@
// Channel   | Direction | Transfer condition         | Payload
// ----------+-----------+----------------------------+------------------------
// request   | in        | start high, busy low       | i_request_size[25:0]
// result    | out       | o_result_strobe high       | o_result_kind[1:0]
// config    | in        | i_cfg_wr_en high           | i_cfg_wr_data[25:0]
//
// The front takes no new request until it has pushed the last (two registered
// multiplies for the alignment round-up, then a push into a 2-entry queue).
// The back steps through start, wrap test and reclaim for a grant, plus a
// sequence step for a padded tail, a reclaim step per extra record; an oversize
// request ends at start. Results leave one per cycle at most and cannot be held
// off. Synchronous active-low reset; free space comes back as 1048576 bytes.
`default_nettype none

module fenced_ring_buffer_allocator #(
    parameter int RECORD_SLOTS = fba_pkg::RECORD_SLOTS_DEF,
    parameter int ALIGN_BYTES  = fba_pkg::ALIGN_BYTES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [fba_pkg::SIZE_W-1:0] i_request_size,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [fba_pkg::SIZE_W-1:0] i_cfg_wr_data,
    output logic                            o_result_strobe,
    output logic [1:0]                      o_result_kind
);
    import fba_pkg::*;

    logic [SIZE_W-1:0] r_ring_capacity;
    logic              q_push, q_pop, q_full, q_empty;
    t_item             q_in_item, q_out_item;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_capacity <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_ring_capacity <= i_cfg_wr_data;
        end
    end

    fba_front #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_request_size  (i_request_size),
        .i_ring_capacity (r_ring_capacity),
        .i_full          (q_full),
        .o_push          (q_push),
        .o_item          (q_in_item)
    );

    fba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_empty (q_empty)
    );

    fba_back #(
        .RECORD_SLOTS (RECORD_SLOTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ring_capacity (r_ring_capacity),
        .i_empty         (q_empty),
        .i_item          (q_out_item),
        .o_pop           (q_pop),
        .o_result_strobe (o_result_strobe),
        .o_result_kind   (o_result_kind)
    );

endmodule

`default_nettype wire

@@ rtl/core/fba_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module fba_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_result_strobe,
    input wire logic [1:0] o_result_kind
);
    import fba_pkg::*;

    // a transfer on the request channel makes the block busy
    `FBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after request")

    // a grant or an oversize reply closes an item: nothing follows directly
    `FBA_ASSERT_NEXT(a_final_gap, o_result_strobe && o_result_kind != KIND_WAIT, !o_result_strobe, "result right after final result")

    // leaving reset shows an idle block
    `FBA_ASSERT_IMPL(a_reset_idle, $rose(i_rst_n), !o_result_strobe && !busy, "block not idle after reset")

endmodule

bind fenced_ring_buffer_allocator fba_checker u_fba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_result_kind   (o_result_kind)
);

`default_nettype wire
